// ----- rtl/cpts_pkg.sv -----
// Shared types and constants for the counter/priority task scheduler.
// Holds the command codes, payload structs, controller states and the
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none

package cpts_pkg;

  localparam int TASK_SLOTS_DEF    = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int CMD_W      = 3;
  localparam int SLOT_FLD_W = 4;
  localparam int PRIO_FLD_W = 8;
  localparam int SLICE_W    = 9;
  localparam int DEPTH_W    = 8;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSTALL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PREEMPT_OFF = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PREEMPT_ON  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [SLOT_FLD_W-1:0] slot;
    logic [PRIO_FLD_W-1:0] task_priority;
  } sched_req_t;

  typedef struct packed {
    logic [SLOT_FLD_W-1:0] current_task;
    logic [SLOT_FLD_W-1:0] previous_task;
    logic                  switched;
    logic                  refilled;
    logic [SLICE_W-1:0]    slice_left;
  } sched_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CUR,
    S_APPLY,
    S_SCAN,
    S_SCAN_TAIL,
    S_DECIDE,
    S_FILL,
    S_FILL_TAIL,
    S_FIN_RD,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and the slot now running
    logic rd_run;     // table read address is the running slot, else the scan index
    logic apply;      // carry out the captured command on the running slot
    logic idx_clr;
    logic idx_inc;
    logic scan_rd;    // read issued for the best-slot search
    logic fill_rd;    // read issued for the counter refill pass
    logic pick_clr;
    logic mark_fill;
    logic commit;     // the search winner becomes the running slot
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_idx;
    logic resched;
    logic need_fill;
    logic fill_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/cpts_ctrl.sv -----
// Controller state machine of the task scheduler.
// Sequences command apply, slot search and refill passes; uses cpts_pkg.
`default_nettype none

module cpts_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire cpts_pkg::sts_t sts,
  output cpts_pkg::ctl_t    ctl,
  output logic              busy
);
  import cpts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_RD_CUR;
      end
      S_RD_CUR:    state_next = S_APPLY;
      S_APPLY:     state_next = sts.resched ? S_SCAN : S_FIN_RD;
      S_SCAN: begin
        if (sts.last_idx) state_next = S_SCAN_TAIL;
      end
      S_SCAN_TAIL: state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.need_fill && !sts.fill_done) begin
          state_next = S_FILL;
        end else begin
          state_next = S_FIN_RD;
        end
      end
      S_FILL: begin
        if (sts.last_idx) state_next = S_FILL_TAIL;
      end
      S_FILL_TAIL: state_next = S_SCAN;
      S_FIN_RD:    state_next = S_EMIT;
      S_EMIT:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_RD_CUR: begin
        ctl.rd_run = 1'b1;
      end
      S_APPLY: begin
        ctl.apply    = 1'b1;
        ctl.idx_clr  = 1'b1;
        ctl.pick_clr = 1'b1;
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        ctl.idx_inc = 1'b1;
      end
      S_SCAN_TAIL: begin
        ctl.rd_run = 1'b1;
      end
      S_DECIDE: begin
        if (sts.need_fill && !sts.fill_done) begin
          ctl.mark_fill = 1'b1;
          ctl.idx_clr   = 1'b1;
        end else begin
          ctl.commit = 1'b1;
        end
      end
      S_FILL: begin
        ctl.fill_rd = 1'b1;
        ctl.idx_inc = 1'b1;
      end
      S_FILL_TAIL: begin
        ctl.idx_clr  = 1'b1;
        ctl.pick_clr = 1'b1;
      end
      S_FIN_RD: begin
        ctl.rd_run = 1'b1;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cpts_dp.sv -----
// Datapath of the task scheduler: slot tables, search and refill logic,
// command execution and the result register. Uses cpts_pkg.
`default_nettype none

module cpts_dp #(
  parameter int TASK_SLOTS    = cpts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cpts_pkg::sched_req_t request,
  input  wire cpts_pkg::ctl_t      ctl,
  output cpts_pkg::sts_t           sts,
  output logic                     done,
  output cpts_pkg::sched_res_t     result
);
  import cpts_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW     = PRIORITY_BITS + 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);

  // Per-slot flags in flip-flops.
  logic [TASK_SLOTS-1:0] valid;
  logic [TASK_SLOTS-1:0] zombie;
  logic [TASK_SLOTS-1:0] count_wr;
  logic [TASK_SLOTS-1:0] prio_wr;
  logic [TASK_SLOTS-1:0] depth_wr;

  // Slot tables. An entry never written reads as its reset value.
  logic [CW-1:0]            count_mem [TASK_SLOTS];
  logic [PRIORITY_BITS-1:0] prio_mem  [TASK_SLOTS];
  logic [DEPTH_W-1:0]       depth_mem [TASK_SLOTS];

  logic [CW-1:0]            count_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [DEPTH_W-1:0]       depth_q;
  logic                     count_ok;
  logic                     prio_ok;
  logic                     depth_ok;
  logic [SLOT_W-1:0]        rd_idx;

  sched_req_t        item;
  logic [SLOT_W-1:0] run;
  logic [SLOT_W-1:0] prev;
  logic [SLOT_W-1:0] idx;
  logic              fill_done;
  logic              pend_pick;
  logic              pend_fill;
  logic              found;
  logic [SLOT_W-1:0] best;
  logic [CW-1:0]     best_cnt;

  logic [SLOT_W-1:0]        raddr;
  logic [CW-1:0]            cnt_val;
  logic [PRIORITY_BITS-1:0] prio_val;
  logic [DEPTH_W-1:0]       dep_val;
  logic [CW-1:0]            tick_cnt;
  logic [CW-1:0]            fill_sum;
  logic                     install_hit;
  logic [SLOT_W-1:0]        inst_idx;
  logic [PRIORITY_BITS-1:0] inst_prio;
  logic [SLOT_FLD_W+SLOT_W-1:0]        slot_ext;
  logic [PRIO_FLD_W+PRIORITY_BITS-1:0] prio_ext;
  logic [SLOT_W+SLOT_FLD_W-1:0]        cur_ext;
  logic [SLOT_W+SLOT_FLD_W-1:0]        prev_ext;
  logic [CW+SLICE_W-1:0]               slice_ext;

  logic                     cnt_we;
  logic [SLOT_W-1:0]        cnt_waddr;
  logic [CW-1:0]            cnt_wdata;
  logic                     prio_we;
  logic                     dep_we;
  logic [SLOT_W-1:0]        dep_waddr;
  logic [DEPTH_W-1:0]       dep_wdata;
  logic                     resched;
  logic                     set_zombie;
  logic                     install;
  logic                     runnable;

  assign raddr = ctl.rd_run ? run : idx;

  assign cnt_val  = count_ok ? count_q : '0;
  assign prio_val = prio_ok ? prio_q :
                    ((rd_idx == '0) ? PRIORITY_BITS'(1) : '0);
  assign dep_val  = depth_ok ? depth_q : '0;

  assign tick_cnt = (cnt_val == '0) ? '0 : cnt_val - CW'(1);
  // Half the counter plus the priority always fits in the counter width.
  assign fill_sum = (cnt_val >> 1) + {1'b0, prio_val};

  assign slot_ext    = {{SLOT_W{1'b0}}, item.slot};
  assign inst_idx    = slot_ext[SLOT_W-1:0];
  assign prio_ext    = {{PRIORITY_BITS{1'b0}}, item.task_priority};
  assign inst_prio   = prio_ext[PRIORITY_BITS-1:0];
  assign install_hit = int'(item.slot) < TASK_SLOTS;

  assign runnable = valid[rd_idx] && !zombie[rd_idx];

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = run;
    cnt_wdata  = '0;
    prio_we    = 1'b0;
    dep_we     = 1'b0;
    dep_waddr  = run;
    dep_wdata  = '0;
    resched    = 1'b0;
    set_zombie = 1'b0;
    install    = 1'b0;
    if (ctl.apply) begin
      case (item.command)
        CMD_TICK: begin
          cnt_we    = 1'b1;
          cnt_wdata = tick_cnt;
          resched   = (tick_cnt == '0) && (dep_val == '0);
        end
        CMD_YIELD: begin
          cnt_we  = 1'b1;
          resched = 1'b1;
        end
        CMD_EXIT: begin
          cnt_we     = 1'b1;
          resched    = 1'b1;
          set_zombie = 1'b1;
        end
        CMD_INSTALL: begin
          if (install_hit) begin
            install   = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = inst_idx;
            cnt_wdata = {1'b0, inst_prio};
            prio_we   = 1'b1;
            dep_we    = 1'b1;
            dep_waddr = inst_idx;
          end
        end
        CMD_PREEMPT_OFF: begin
          if (dep_val != '1) begin
            dep_we    = 1'b1;
            dep_wdata = dep_val + DEPTH_W'(1);
          end
        end
        CMD_PREEMPT_ON: begin
          if (dep_val != '0) begin
            dep_we    = 1'b1;
            dep_wdata = dep_val - DEPTH_W'(1);
          end
        end
        default: begin
          resched = 1'b0;
        end
      endcase
    end else if (pend_fill && valid[rd_idx]) begin
      cnt_we    = 1'b1;
      cnt_waddr = rd_idx;
      cnt_wdata = fill_sum;
    end
  end

  // Table ports: one write and one registered read per table.
  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
    if (prio_we) prio_mem[inst_idx] <= inst_prio;
    if (dep_we) depth_mem[dep_waddr] <= dep_wdata;
    count_q  <= count_mem[raddr];
    prio_q   <= prio_mem[raddr];
    depth_q  <= depth_mem[raddr];
    count_ok <= count_wr[raddr];
    prio_ok  <= prio_wr[raddr];
    depth_ok <= depth_wr[raddr];
    rd_idx   <= raddr;
    if (ctl.load) item <= request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= TASK_SLOTS'(1);
      zombie    <= '0;
      count_wr  <= '0;
      prio_wr   <= '0;
      depth_wr  <= '0;
      run       <= '0;
      prev      <= '0;
      idx       <= '0;
      fill_done <= 1'b0;
      pend_pick <= 1'b0;
      pend_fill <= 1'b0;
      found     <= 1'b0;
      best      <= '0;
      best_cnt  <= '0;
      done      <= 1'b0;
    end else begin
      if (cnt_we) count_wr[cnt_waddr] <= 1'b1;
      if (prio_we) prio_wr[inst_idx] <= 1'b1;
      if (dep_we) depth_wr[dep_waddr] <= 1'b1;
      if (install) begin
        valid[inst_idx]  <= 1'b1;
        zombie[inst_idx] <= 1'b0;
      end
      if (set_zombie) zombie[run] <= 1'b1;

      if (ctl.load) begin
        prev      <= run;
        fill_done <= 1'b0;
      end
      if (ctl.mark_fill) fill_done <= 1'b1;

      if (ctl.idx_clr) begin
        idx <= '0;
      end else if (ctl.idx_inc) begin
        idx <= idx + SLOT_W'(1);
      end

      pend_pick <= ctl.scan_rd;
      pend_fill <= ctl.fill_rd;

      // Strictly greater keeps the lowest index on ties.
      if (ctl.pick_clr) begin
        found    <= 1'b0;
        best     <= '0;
        best_cnt <= '0;
      end else if (pend_pick && runnable && (!found || cnt_val > best_cnt)) begin
        found    <= 1'b1;
        best     <= rd_idx;
        best_cnt <= cnt_val;
      end

      if (ctl.commit) run <= found ? best : '0;

      done <= ctl.emit;
    end
  end

  assign cur_ext   = {{SLOT_FLD_W{1'b0}}, run};
  assign prev_ext  = {{SLOT_FLD_W{1'b0}}, prev};
  assign slice_ext = {{SLICE_W{1'b0}}, cnt_val};

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.current_task  <= cur_ext[SLOT_FLD_W-1:0];
      result.previous_task <= prev_ext[SLOT_FLD_W-1:0];
      result.switched      <= (run != prev);
      result.refilled      <= fill_done;
      result.slice_left    <= slice_ext[SLICE_W-1:0];
    end
  end

  assign sts.last_idx  = (idx == LAST_IDX);
  assign sts.resched   = resched;
  assign sts.need_fill = found && (best_cnt == '0);
  assign sts.fill_done = fill_done;

endmodule

`default_nettype wire

// ----- rtl/counter_priority_task_scheduler.sv -----
// Top level of the counter/priority task scheduler.
// Joins the controller (cpts_ctrl) and the datapath (cpts_dp); uses cpts_pkg.
//
//   Channel   Ports                  Handshake
//   command   start, busy, request   transfer when start is high and busy is low
//   result    done, result           one-cycle strobe, one result per command
//
// A command that reschedules runs a search of the slot tables before done rises,
// and one that refills the counters adds a refill pass and a second search:
// each search and the refill pass walk the slot tables one entry per cycle
// through a single read port. busy is low again in the cycle that done is high.
// Reset is synchronous; after it slot 0 runs with priority 1. The receiver
// cannot stall, so results are never held back.
`default_nettype none

module counter_priority_task_scheduler #(
  parameter int TASK_SLOTS    = cpts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cpts_pkg::sched_req_t request,
  output logic                      done,
  output cpts_pkg::sched_res_t      result
);
  import cpts_pkg::*;

  ctl_t ctl;
  sts_t sts;

  cpts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  cpts_dp #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire

// ----- sim/cpts_checker.sv -----
// Scoreboard for the counter/priority task scheduler. It keeps its own copy of
// the slot tables, predicts the result of every command transfer and compares
// each result strobe with the oldest prediction. Depends on cpts_pkg.
module cpts_checker
  import cpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  sched_req_t request,
  input  logic       done,
  input  sched_res_t result,
  output int         errors,
  output int         outstanding,
  output int         results_seen,
  output int         refill_count
);

  localparam int                 SLOTS     = TASK_SLOTS_DEF;
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  logic                  valid_tbl  [SLOTS];
  logic                  zombie_tbl [SLOTS];
  logic [SLICE_W-1:0]    slice_tbl  [SLOTS];
  logic [PRIO_FLD_W-1:0] prio_tbl   [SLOTS];
  logic [DEPTH_W-1:0]    depth_tbl  [SLOTS];
  logic [SLOT_FLD_W-1:0] running;

  sched_res_t due_results[$];
  sched_res_t want;
  int         n_err    = 0;
  int         n_seen   = 0;
  int         n_refill = 0;

  task automatic clear_tables();
    for (int i = 0; i < SLOTS; i++) begin
      valid_tbl[i]  = (i == 0);
      zombie_tbl[i] = 1'b0;
      slice_tbl[i]  = '0;
      prio_tbl[i]   = (i == 0) ? PRIO_FLD_W'(1) : '0;
      depth_tbl[i]  = '0;
    end
    running = '0;
  endtask

  // Runnable slot with the largest counter; the strict compare keeps the
  // lowest index on ties. Slot 0 when nothing is runnable.
  function automatic logic [SLOT_FLD_W-1:0] best_slot(output logic found);
    logic [SLOT_FLD_W-1:0] best;
    best  = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_tbl[i] && !zombie_tbl[i] && (!found || slice_tbl[i] > slice_tbl[best])) begin
        best  = i[SLOT_FLD_W-1:0];
        found = 1'b1;
      end
    end
    return best;
  endfunction

  // Picks the next task, refilling every valid slot (zombies included) once
  // when the best runnable counter is zero. Returns whether a refill happened.
  function automatic logic pick_task();
    logic                  found;
    logic                  refill;
    logic [SLOT_FLD_W-1:0] winner;
    logic [SLICE_W:0]      refill_val;
    refill = 1'b0;
    winner = best_slot(found);
    if (found && slice_tbl[winner] == '0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_tbl[i]) begin
          refill_val   = {2'b00, slice_tbl[i][SLICE_W-1:1]} + {2'b00, prio_tbl[i]};
          slice_tbl[i] = (refill_val > {1'b0, SLICE_MAX}) ? SLICE_MAX
                                                          : refill_val[SLICE_W-1:0];
        end
      end
      refill = 1'b1;
      winner = best_slot(found);
    end
    running = winner;
    return refill;
  endfunction

  function automatic sched_res_t apply_command(sched_req_t r);
    sched_res_t            res;
    logic [SLOT_FLD_W-1:0] prev;
    logic                  refill;
    prev   = running;
    refill = 1'b0;
    case (r.command)
      CMD_TICK: begin
        if (slice_tbl[prev] != '0)
          slice_tbl[prev] = slice_tbl[prev] - SLICE_W'(1);
        if (slice_tbl[prev] == '0 && depth_tbl[prev] == '0)
          refill = pick_task();
      end
      CMD_YIELD: begin
        slice_tbl[prev] = '0;
        refill = pick_task();
      end
      CMD_EXIT: begin
        zombie_tbl[prev] = 1'b1;
        slice_tbl[prev]  = '0;
        refill = pick_task();
      end
      CMD_INSTALL: begin
        valid_tbl[r.slot]  = 1'b1;
        zombie_tbl[r.slot] = 1'b0;
        slice_tbl[r.slot]  = {1'b0, r.task_priority};
        prio_tbl[r.slot]   = r.task_priority;
        depth_tbl[r.slot]  = '0;
      end
      CMD_PREEMPT_OFF: begin
        if (depth_tbl[prev] != DEPTH_MAX)
          depth_tbl[prev] = depth_tbl[prev] + DEPTH_W'(1);
      end
      CMD_PREEMPT_ON: begin
        if (depth_tbl[prev] != '0)
          depth_tbl[prev] = depth_tbl[prev] - DEPTH_W'(1);
      end
      default: ;
    endcase
    res.current_task  = running;
    res.previous_task = prev;
    res.switched      = (running != prev);
    res.refilled      = refill;
    res.slice_left    = slice_tbl[running];
    return res;
  endfunction

  task automatic check_field(string name, logic [SLICE_W-1:0] exp_v, logic [SLICE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      due_results.delete();
    end else begin
      // Results are retired before a new transfer is predicted, since busy
      // drops in the cycle that done is high.
      if (done) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no command outstanding, got %p", $time, result);
          n_err++;
        end else begin
          want = due_results.pop_front();
          n_seen++;
          if (want.refilled)
            n_refill++;
          check_field("current_task", SLICE_W'(want.current_task),
                      SLICE_W'(result.current_task));
          check_field("previous_task", SLICE_W'(want.previous_task),
                      SLICE_W'(result.previous_task));
          check_field("switched", SLICE_W'(want.switched), SLICE_W'(result.switched));
          check_field("refilled", SLICE_W'(want.refilled), SLICE_W'(result.refilled));
          check_field("slice_left", want.slice_left, result.slice_left);
        end
      end
      if (start && !busy)
        due_results.push_back(apply_command(request));
    end
    errors       <= n_err;
    outstanding  <= due_results.size();
    results_seen <= n_seen;
    refill_count <= n_refill;
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the scheduler testbench: clock, reset, command stimulus and verdict.
// Instantiates counter_priority_task_scheduler and cpts_checker; uses cpts_pkg.
module testbench;
  import cpts_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_A   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B   = 3'd7;
  localparam int               IDLE_LIMIT   = 2000;
  localparam int               DRAIN_CYCLES = 3 * TASK_SLOTS_DEF + 16;
  localparam int               PHASE_ITEMS  = 330;

  logic       clk     = 1'b0;
  logic       rst     = 1'b1;
  logic       start   = 1'b0;
  sched_req_t request = '0;
  logic       busy;
  logic       done;
  sched_res_t result;

  int errors;
  int outstanding;
  int results_seen;
  int refill_count;
  int sent     = 0;
  int quiet    = 0;
  int idle_pct = 0;
  int pacing[4] = '{0, 50, 0, 31};

  counter_priority_task_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  cpts_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .done         (done),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .refill_count (refill_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: counts cycles with neither a command transfer nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Holds start until the transfer, then sometimes leaves a gap before the
  // next command. start stays high between back-to-back commands.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [SLOT_FLD_W-1:0] slot,
                       logic [PRIO_FLD_W-1:0] prio);
    start   <= 1'b1;
    request <= '{command: cmd, slot: slot, task_priority: prio};
    do @(posedge clk); while (busy);
    sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Ticks lead the mix and priorities are mostly small, so counters run out
  // and refills come often; installs keep the table populated against exits.
  task automatic random_command();
    int                    r;
    int                    p;
    logic [CMD_W-1:0]      cmd;
    logic [PRIO_FLD_W-1:0] prio;
    r = $urandom_range(99);
    p = $urandom_range(99);
    if (p < 5)
      prio = '0;
    else if (p < 70)
      prio = PRIO_FLD_W'($urandom_range(1, 6));
    else
      prio = PRIO_FLD_W'($urandom_range(1, 255));
    if (r < 44)
      cmd = CMD_TICK;
    else if (r < 54)
      cmd = CMD_YIELD;
    else if (r < 61)
      cmd = CMD_EXIT;
    else if (r < 79)
      cmd = CMD_INSTALL;
    else if (r < 87)
      cmd = CMD_PREEMPT_OFF;
    else if (r < 97)
      cmd = CMD_PREEMPT_ON;
    else
      cmd = r[0] ? CMD_RSVD_A : CMD_RSVD_B;
    issue(cmd, SLOT_FLD_W'($urandom_range(15)), prio);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: refill straight out of reset, unused command codes,
    // ticks while preemption is held, and field extremes.
    issue(CMD_TICK, 4'd0, 8'd0);
    issue(CMD_RSVD_A, 4'd15, 8'd255);
    issue(CMD_RSVD_B, 4'd0, 8'd0);
    issue(CMD_PREEMPT_OFF, 4'd0, 8'd0);
    issue(CMD_TICK, 4'd0, 8'd0);
    issue(CMD_TICK, 4'd0, 8'd0);
    issue(CMD_PREEMPT_ON, 4'd0, 8'd0);
    issue(CMD_PREEMPT_ON, 4'd0, 8'd0);
    issue(CMD_INSTALL, 4'd15, 8'd255);
    issue(CMD_INSTALL, 4'd1, 8'd1);
    issue(CMD_INSTALL, 4'd2, 8'd0);
    issue(CMD_INSTALL, 4'd0, 8'd128);
    issue(CMD_YIELD, 4'd0, 8'd0);
    issue(CMD_TICK, 4'd0, 8'd0);
    issue(CMD_EXIT, 4'd0, 8'd0);
    issue(CMD_INSTALL, 4'd3, 8'd0);
    issue(CMD_EXIT, 4'd0, 8'd0);
    issue(CMD_YIELD, 4'd0, 8'd0);
    // Remaining tasks have priority zero, so the refill leaves them at zero.
    issue(CMD_EXIT, 4'd0, 8'd0);
    issue(CMD_EXIT, 4'd0, 8'd0);
    // Nothing runnable is left: slot 0 keeps running as a zombie.
    issue(CMD_EXIT, 4'd0, 8'd0);
    issue(CMD_TICK, 4'd0, 8'd0);
    issue(CMD_YIELD, 4'd0, 8'd0);
    issue(CMD_INSTALL, 4'd5, 8'd85);
    issue(CMD_INSTALL, 4'd10, 8'd170);
    issue(CMD_YIELD, 4'd0, 8'd0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pacing[ph];
      if (ph == 1) begin
        // Drive the running task's preemption depth past saturation, tick it
        // while held, then retire it so the pinned depth does not linger.
        repeat (257) issue(CMD_PREEMPT_OFF, SLOT_FLD_W'($urandom_range(15)), 8'd0);
        issue(CMD_TICK, 4'd0, 8'd0);
        issue(CMD_TICK, 4'd0, 8'd0);
        issue(CMD_EXIT, 4'd0, 8'd0);
      end
      repeat (PHASE_ITEMS) random_command();
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d scheduler commands over four pacing phases, including a saturating",
             sent);
    $display("preemption burst; %0d results checked, %0d of them with a counter refill.",
             results_seen, refill_count);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cpts_pkg.sv
rtl/cpts_ctrl.sv
rtl/cpts_dp.sv
rtl/counter_priority_task_scheduler.sv
sim/cpts_checker.sv
sim/testbench.sv
